FILE: sv/bgms_pkg.sv
// ----------------------------------------------------------------------------
// Button gesture mode selector package
// Shared codes for key classification, selection phases, beeps and registers.
// ----------------------------------------------------------------------------
package bgms_pkg;

    localparam logic [1:0] KS_FREE    = 2'd0;
    localparam logic [1:0] KS_PRESS   = 2'd1;
    localparam logic [1:0] KS_RELEASE = 2'd2;
    localparam logic [1:0] KS_HELD    = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ENTER = 2'd1;
    localparam logic [1:0] PH_COUNT = 2'd2;
    localparam logic [1:0] PH_EXIT  = 2'd3;

    localparam logic [2:0] BEEP_NONE    = 3'd0;
    localparam logic [2:0] BEEP_ENTER   = 3'd1;
    localparam logic [2:0] BEEP_CONFIRM = 3'd2;
    localparam logic [2:0] BEEP_COUNT   = 3'd3;
    localparam logic [2:0] BEEP_EXIT    = 3'd4;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_WINDOW = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASED      = 8'd3;

    localparam logic [15:0] LONG_PRESS_RESET    = 16'd500;
    localparam logic [15:0] DOUBLE_WINDOW_RESET = 16'd400;
    localparam logic [7:0]  SAMPLE_PERIOD_RESET = 8'd50;
    localparam logic [2:0]  MAX_MODE            = 3'd5;

    typedef struct packed {
        logic [1:0] key_state;
        logic [1:0] select_phase;
        logic [7:0] click_tally;
        logic [2:0] chosen_mode;
        logic       mode_committed;
        logic       running;
        logic [2:0] beep_code;
    } result_t;

endpackage

FILE: sv/button_gesture_mode_selector.sv
// ----------------------------------------------------------------------------
// Button gesture mode selector
// Classifies a sampled key per tick, runs the mode selection machine and the
// double-click run/stop toggle, and reports one result beat per input beat.
// ----------------------------------------------------------------------------
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while out_ready is high; the whole tick update is one registered step.
// in_ready stays high while the result register is empty or being drained.
// Reset clears the state to idle, stopped, levels released, and loads the
// register defaults; configuration writes are taken every cycle.
module button_gesture_mode_selector
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bgms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             key_level,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       key_state,
    output logic [1:0]                       select_phase,
    output logic [7:0]                       click_tally,
    output logic [2:0]                       chosen_mode,
    output logic                             mode_committed,
    output logic                             running,
    output logic [2:0]                       beep_code
);

    logic [15:0] long_press_reg;
    logic [15:0] double_window_reg;
    logic [7:0]  sample_period_reg;
    logic        released_reg;

    logic        previous_level_reg, previous_level_next;
    logic        captured_level_reg, captured_level_next;
    logic [7:0]  sample_divider_reg, sample_divider_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] hold_counter_reg, hold_counter_next;
    logic [7:0]  press_tally_reg, press_tally_next;
    logic [2:0]  mode_code_reg, mode_code_next;
    logic        run_flag_reg, run_flag_next;
    logic [1:0]  edge_count_reg, edge_count_next;
    logic [15:0] window_timer_reg, window_timer_next;

    logic                 out_valid_reg;
    bgms_pkg::result_t    result_reg, result_next;
    logic                 in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg    <= bgms_pkg::LONG_PRESS_RESET;
            double_window_reg <= bgms_pkg::DOUBLE_WINDOW_RESET;
            sample_period_reg <= bgms_pkg::SAMPLE_PERIOD_RESET;
            released_reg      <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bgms_pkg::REG_LONG_PRESS:    long_press_reg    <= cfg_data;
                bgms_pkg::REG_DOUBLE_WINDOW: double_window_reg <= cfg_data;
                bgms_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[7:0];
                bgms_pkg::REG_RELEASED:      released_reg      <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        logic [1:0]  ks;
        logic [2:0]  beep;
        logic        committed;
        logic [7:0]  period;
        ks                  = bgms_pkg::KS_FREE;
        beep                = bgms_pkg::BEEP_NONE;
        committed           = 1'b0;
        period              = 8'd1;
        previous_level_next = previous_level_reg;
        captured_level_next = captured_level_reg;
        sample_divider_next = sample_divider_reg;
        phase_next          = phase_reg;
        hold_counter_next   = hold_counter_reg;
        press_tally_next    = press_tally_reg;
        mode_code_next      = mode_code_reg;
        run_flag_next       = run_flag_reg;
        edge_count_next     = edge_count_reg;
        window_timer_next   = window_timer_reg;

        if (previous_level_reg == released_reg)
            ks = (captured_level_reg == released_reg) ? bgms_pkg::KS_FREE
                                                      : bgms_pkg::KS_PRESS;
        else
            ks = (captured_level_reg == released_reg) ? bgms_pkg::KS_RELEASE
                                                      : bgms_pkg::KS_HELD;
        previous_level_next = captured_level_reg;

        case (phase_reg)
            bgms_pkg::PH_IDLE:
            begin
                if (ks == bgms_pkg::KS_HELD)
                begin
                    hold_counter_next = (&hold_counter_reg) ? hold_counter_reg
                                                            : hold_counter_reg + 16'd1;
                    if (hold_counter_next >= long_press_reg)
                    begin
                        phase_next        = bgms_pkg::PH_ENTER;
                        hold_counter_next = 16'd0;
                        press_tally_next  = 8'd0;
                        beep              = bgms_pkg::BEEP_ENTER;
                    end
                end
                else
                    hold_counter_next = 16'd0;
            end
            bgms_pkg::PH_ENTER:
            begin
                if (ks == bgms_pkg::KS_RELEASE)
                begin
                    phase_next = bgms_pkg::PH_COUNT;
                    beep       = bgms_pkg::BEEP_CONFIRM;
                end
            end
            bgms_pkg::PH_COUNT:
            begin
                if (ks == bgms_pkg::KS_HELD)
                begin
                    hold_counter_next = (&hold_counter_reg) ? hold_counter_reg
                                                            : hold_counter_reg + 16'd1;
                    if (hold_counter_next >= long_press_reg)
                    begin
                        phase_next        = bgms_pkg::PH_EXIT;
                        hold_counter_next = 16'd0;
                    end
                end
                else
                    hold_counter_next = 16'd0;
                if (ks == bgms_pkg::KS_PRESS)
                begin
                    press_tally_next = press_tally_reg + 8'd1;
                    beep             = bgms_pkg::BEEP_COUNT;
                end
            end
            default:
            begin
                if (ks == bgms_pkg::KS_RELEASE)
                begin
                    if (press_tally_reg <= {5'd0, bgms_pkg::MAX_MODE})
                        mode_code_next = press_tally_reg[2:0];
                    if (mode_code_next != 3'd0)
                        run_flag_next = 1'b0;
                    beep       = bgms_pkg::BEEP_EXIT;
                    committed  = 1'b1;
                    phase_next = bgms_pkg::PH_IDLE;
                end
            end
        endcase

        if (phase_next != bgms_pkg::PH_IDLE)
        begin
            edge_count_next   = 2'd0;
            window_timer_next = 16'd0;
        end
        else
        begin
            if (ks == bgms_pkg::KS_PRESS)
            begin
                edge_count_next = edge_count_reg + 2'd1;
                if (edge_count_next == 2'd1)
                    window_timer_next = 16'd0;
            end
            if (edge_count_next != 2'd0)
            begin
                window_timer_next = (&window_timer_next) ? window_timer_next
                                                         : window_timer_next + 16'd1;
                if (edge_count_next >= 2'd2)
                begin
                    run_flag_next     = !run_flag_next;
                    edge_count_next   = 2'd0;
                    window_timer_next = 16'd0;
                end
                else if (window_timer_next >= double_window_reg)
                begin
                    edge_count_next   = 2'd0;
                    window_timer_next = 16'd0;
                end
            end
        end

        period              = (sample_period_reg == 8'd0) ? 8'd1 : sample_period_reg;
        sample_divider_next = sample_divider_reg + 8'd1;
        if (sample_divider_next >= period)
        begin
            sample_divider_next = 8'd0;
            captured_level_next = key_level;
        end

        result_next.key_state      = ks;
        result_next.select_phase   = phase_next;
        result_next.click_tally    = press_tally_next;
        result_next.chosen_mode    = mode_code_next;
        result_next.mode_committed = committed;
        result_next.running        = run_flag_next;
        result_next.beep_code      = beep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_level_reg <= 1'b1;
            captured_level_reg <= 1'b1;
            sample_divider_reg <= 8'd0;
            phase_reg          <= bgms_pkg::PH_IDLE;
            hold_counter_reg   <= 16'd0;
            press_tally_reg    <= 8'd0;
            mode_code_reg      <= 3'd0;
            run_flag_reg       <= 1'b0;
            edge_count_reg     <= 2'd0;
            window_timer_reg   <= 16'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                previous_level_reg <= previous_level_next;
                captured_level_reg <= captured_level_next;
                sample_divider_reg <= sample_divider_next;
                phase_reg          <= phase_next;
                hold_counter_reg   <= hold_counter_next;
                press_tally_reg    <= press_tally_next;
                mode_code_reg      <= mode_code_next;
                run_flag_reg       <= run_flag_next;
                edge_count_reg     <= edge_count_next;
                window_timer_reg   <= window_timer_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign key_state      = result_reg.key_state;
    assign select_phase   = result_reg.select_phase;
    assign click_tally    = result_reg.click_tally;
    assign chosen_mode    = result_reg.chosen_mode;
    assign mode_committed = result_reg.mode_committed;
    assign running        = result_reg.running;
    assign beep_code      = result_reg.beep_code;

    // A commit always beeps exit and leaves the machine idle.
    a_commit_exit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.mode_committed |->
            result_reg.beep_code == bgms_pkg::BEEP_EXIT &&
            result_reg.select_phase == bgms_pkg::PH_IDLE)
        else $error("commit beat without exit beep or idle phase");

    // The double-click tracker is held clear while a selection is active.
    a_dclick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != bgms_pkg::PH_IDLE |->
            edge_count_reg == 2'd0 && window_timer_reg == 16'd0)
        else $error("double-click state active during selection");

    // The hold counter restarts when a long hold changes the phase.
    a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bgms_pkg::PH_ENTER || phase_reg == bgms_pkg::PH_EXIT |->
            hold_counter_reg == 16'd0)
        else $error("hold counter not cleared after a long hold");

    // The committed mode never leaves the valid range.
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_code_reg <= bgms_pkg::MAX_MODE)
        else $error("mode code out of range");

    // A stopped run state follows every commit of a nonzero mode.
    a_commit_stop: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && result_next.mode_committed && result_next.chosen_mode != 3'd0 |=>
            !run_flag_reg)
        else $error("run state not stopped after a mode commit");

endmodule
